[sv/utf8d_pkg.sv]
// Package for the UTF-8 decoder and classifier: result types, status and lead codes,
// byte constants and the letter classification functions.
// Depends on nothing; utf8d_outq and utf8_decode_classify import it.
package utf8d_pkg;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_TRUNC = 2'd2,
		ST_FOUR  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LK_OTHER = 2'd0,
		LK_C2    = 2'd1,
		LK_C3    = 2'd2
	} lead_t;

	localparam logic [7:0]  LEAD_C2       = 8'hC2;
	localparam logic [7:0]  LEAD_C3       = 8'hC3;
	localparam logic [15:0] MODIFIER_LO   = 16'h02B0;
	localparam logic [15:0] MODIFIER_HI   = 16'h02FF;
	localparam logic [15:0] COMBINING_LO  = 16'h0300;
	localparam logic [15:0] COMBINING_HI  = 16'h036F;
	localparam logic [15:0] PUNCT_LO      = 16'h2000;
	localparam logic [15:0] PUNCT_HI      = 16'h2FFF;

	// Result queue depth; a power of two so that the pointers wrap on their own.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [15:0] code_point;
		logic        is_letter;
		status_t     status;
		logic [15:0] char_count;
		logic        is_last;
	} res_t;

	// Up to two results are written into the queue for one accepted byte.
	typedef struct packed {
		logic [1:0] n;
		res_t       a;
		res_t       b;
	} push_t;

	function automatic logic latin1_letter(input logic [15:0] cp);
		logic r;
		r = 1'b0;
		if (cp >= 16'h0041 && cp <= 16'h005A) r = 1'b1;
		if (cp >= 16'h0061 && cp <= 16'h007A) r = 1'b1;
		if (cp >= 16'h00C0 && cp <= 16'h00FF && cp != 16'h00D7 && cp != 16'h00F7) r = 1'b1;
		return r;
	endfunction

	function automatic logic wide_letter(input logic [15:0] cp, input logic l1_only);
		logic r;
		r = !l1_only;
		if (cp >= MODIFIER_LO && cp <= MODIFIER_HI) r = 1'b0;
		if (cp >= COMBINING_LO && cp <= COMBINING_HI) r = 1'b0;
		if (cp >= PUNCT_LO && cp <= PUNCT_HI) r = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_res(input logic [15:0] cp, input logic letter,
			input status_t st, input logic [15:0] cnt);
		res_t r;
		r.code_point = cp;
		r.is_letter  = letter;
		r.status     = st;
		r.char_count = cnt;
		r.is_last    = 1'b0;
		return r;
	endfunction

endpackage

[sv/utf8d_if.sv]
// Channel interfaces of the UTF-8 decoder: byte input, result output and configuration.
// Each carries valid, ready and its payload; no package is needed.
interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;
	modport source (output valid, in_byte, end_of_string, input ready);
	modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface utf8d_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_point;
	logic        is_letter;
	logic [1:0]  status;
	logic [15:0] char_count;
	logic        is_last;
	modport source (output valid, code_point, is_letter, status, char_count, is_last,
		input ready);
	modport sink   (input valid, code_point, is_letter, status, char_count, is_last,
		output ready);
endinterface

interface utf8d_cfg_if;
	logic valid;
	logic ready;
	logic latin1_only;
	modport source (output valid, latin1_only, input ready);
	modport sink   (input valid, latin1_only, output ready);
endinterface

[sv/utf8d_outq.sv]
// Result queue of the UTF-8 decoder: takes up to two results a cycle, gives one.
// Depends on utf8d_pkg and utf8d_out_if.
module utf8d_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  utf8d_pkg::push_t push,
	output logic             room,
	utf8d_out_if.source      chars
);
	import utf8d_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	res_t              head;

	assign pop  = chars.valid && chars.ready;
	// Space for a full pair must be free before another byte is taken.
	assign room = count_q <= QCNT_W'(QDEPTH - 2);
	assign head = mem_q[rptr_q];

	assign chars.valid      = count_q != '0;
	assign chars.code_point = head.code_point;
	assign chars.is_letter  = head.is_letter;
	assign chars.status     = head.status;
	assign chars.char_count = head.char_count;
	assign chars.is_last    = head.is_last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wptr_q] <= push.a;
		if (push.n == 2'd2) mem_q[wptr_q + QPTR_W'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QPTR_W'(push.n);
			rptr_q  <= rptr_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

[sv/utf8_decode_classify.sv]
// Top level of the UTF-8 decoder and letter classifier: decode state and result selection.
// Depends on utf8d_pkg, the interfaces in utf8d_if and the result queue utf8d_outq.
//
//   channel  dir  payload                                             accepted when
//   cfg      in   latin1_only                                         valid && ready
//   utf8     in   in_byte, end_of_string                              valid && ready
//   chars    out  code_point, is_letter, status, char_count, is_last  valid && ready
//
// One byte request is taken in every cycle while the result queue holds at most two
// entries; the decode is a single pass of logic from the byte and the state registers
// into the queue, so each result is registered in the queue as its byte is taken.
// A byte gives zero, one or two results; with one result per byte and the output always
// ready the block keeps one byte per cycle, and pairs are drained at one per cycle.
// Reset clears the partial character, the count and latin1_only; the queue pointers clear.
// A stalled output holds its result while the queue fills, and the byte channel then
// drops ready; configuration requests are always taken.
module utf8_decode_classify #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	utf8d_cfg_if.sink    cfg,
	utf8d_in_if.sink     utf8,
	utf8d_out_if.source  chars
);
	import utf8d_pkg::*;

	// Decode state: bits gathered so far, continuation bytes still due, which lead
	// byte opened the sequence, and whether it is a four-byte one.
	logic [15:0]            partial_q;
	logic [1:0]             bytes_left_q;
	lead_t                  lead_kind_q;
	logic                   four_q;
	logic [COUNT_WIDTH-1:0] chars_q;
	logic                   l1_q;

	logic [15:0]            partial_d;
	logic [1:0]             bytes_left_d;
	lead_t                  lead_kind_d;
	logic                   four_d;
	logic [COUNT_WIDTH-1:0] chars_d;

	logic                   room;
	logic                   acc;
	logic [7:0]             b;
	logic                   eos;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [15:0]            cur16;
	logic [15:0]            inc16;
	logic [15:0]            step16;
	logic [15:0]            shifted;
	logic [1:0]             left_dec;

	// The three ways a byte can produce a result. The abandoned-sequence report always
	// comes first; a finished character and the end-of-string report never come together.
	logic                   ev_abandon;
	logic                   ev_main;
	logic                   ev_endtrunc;
	res_t                   r_abandon;
	res_t                   r_main;
	res_t                   r_endtrunc;
	res_t                   r_rest;
	logic [1:0]             n_res;
	push_t                  push;

	assign b   = utf8.in_byte;
	assign eos = utf8.end_of_string;
	assign acc = utf8.valid && room;

	assign utf8.ready = room;
	assign cfg.ready  = 1'b1;

	// The count saturates at its top value; the result carries its low sixteen bits.
	assign cnt_inc  = (chars_q == {COUNT_WIDTH{1'b1}}) ? chars_q : chars_q + COUNT_WIDTH'(1);
	assign cur16    = 16'(chars_q);
	assign inc16    = 16'(cnt_inc);
	assign shifted  = {partial_q[9:0], b[5:0]};
	assign left_dec = bytes_left_q - 2'd1;

	always_comb begin
		partial_d    = partial_q;
		bytes_left_d = bytes_left_q;
		lead_kind_d  = lead_kind_q;
		four_d       = four_q;
		chars_d      = chars_q;
		step16       = cur16;
		ev_abandon   = 1'b0;
		ev_main      = 1'b0;
		r_main       = mk_res(16'd0, 1'b0, ST_BAD, cur16);
		r_abandon    = mk_res(16'd0, 1'b0, ST_TRUNC, cur16);

		if (b[7:6] == 2'b10) begin
			// Continuation byte.
			if (bytes_left_q != 2'd0) begin
				if (left_dec == 2'd0) begin
					ev_main = 1'b1;
					if (four_q) begin
						r_main = mk_res(16'd0, 1'b0, ST_FOUR, cur16);
					end else if (lead_kind_q != LK_OTHER) begin
						r_main = mk_res(shifted, latin1_letter(shifted), ST_OK, cur16);
					end else begin
						r_main = mk_res(shifted, wide_letter(shifted, l1_q), ST_OK, cur16);
					end
					partial_d    = 16'd0;
					bytes_left_d = 2'd0;
					lead_kind_d  = LK_OTHER;
					four_d       = 1'b0;
				end else begin
					partial_d    = shifted;
					bytes_left_d = left_dec;
				end
			end else begin
				// Stray continuation: reported, not counted.
				ev_main = 1'b1;
			end
		end else begin
			// Any other byte starts a character and abandons whatever was pending.
			ev_abandon   = bytes_left_q != 2'd0;
			partial_d    = 16'd0;
			bytes_left_d = 2'd0;
			lead_kind_d  = LK_OTHER;
			four_d       = 1'b0;
			chars_d      = cnt_inc;
			step16       = inc16;
			if (!b[7]) begin
				ev_main = 1'b1;
				r_main  = mk_res({8'd0, b}, latin1_letter({8'd0, b}), ST_OK, inc16);
			end else if (b[7:5] == 3'b110) begin
				partial_d    = {11'd0, b[4:0]};
				bytes_left_d = 2'd1;
				if (b == LEAD_C2) begin
					lead_kind_d = LK_C2;
				end else if (b == LEAD_C3) begin
					lead_kind_d = LK_C3;
				end
			end else if (b[7:4] == 4'b1110) begin
				partial_d    = {12'd0, b[3:0]};
				bytes_left_d = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				bytes_left_d = 2'd3;
				four_d       = 1'b1;
			end else begin
				// Lead bytes from 0xF8 up are counted and rejected at once.
				ev_main = 1'b1;
				r_main  = mk_res(16'd0, 1'b0, ST_BAD, inc16);
			end
		end

		// The end byte reports a sequence left open and returns the state to reset.
		ev_endtrunc = eos && (bytes_left_d != 2'd0);
		r_endtrunc  = mk_res(16'd0, 1'b0, ST_TRUNC, step16);
		if (eos) begin
			partial_d    = 16'd0;
			bytes_left_d = 2'd0;
			lead_kind_d  = LK_OTHER;
			four_d       = 1'b0;
			chars_d      = '0;
		end
	end

	always_comb begin
		n_res  = 2'(ev_abandon) + 2'(ev_main) + 2'(ev_endtrunc);
		r_rest = ev_main ? r_main : r_endtrunc;
		push.a = ev_abandon ? r_abandon : r_rest;
		push.b = r_rest;
		if (eos) begin
			if (n_res == 2'd2) begin
				push.b.is_last = 1'b1;
			end else begin
				push.a.is_last = 1'b1;
			end
		end
		push.n = acc ? n_res : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= 16'd0;
			bytes_left_q <= 2'd0;
			lead_kind_q  <= LK_OTHER;
			four_q       <= 1'b0;
			chars_q      <= '0;
		end else if (acc) begin
			partial_q    <= partial_d;
			bytes_left_q <= bytes_left_d;
			lead_kind_q  <= lead_kind_d;
			four_q       <= four_d;
			chars_q      <= chars_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 1'b0;
		end else if (cfg.valid) begin
			l1_q <= cfg.latin1_only;
		end
	end

	utf8d_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.chars  (chars)
	);

`ifndef NO_ASSERTIONS
	// An end byte leaves no partial character and a fresh count behind it.
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && eos |=> bytes_left_q == 2'd0 && chars_q == '0 && !four_q)
		else $error("state not cleared after end of string");

	// Every end byte must give at least one result.
	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && eos |-> push.n != 2'd0)
		else $error("end byte gave no result");

	// A four-byte marker only lives while continuation bytes are still due.
	a_four_pending: assert property (@(posedge clk) disable iff (!arst_n)
		four_q |-> bytes_left_q != 2'd0)
		else $error("four-byte flag without a pending sequence");

	// A 0xC2 or 0xC3 lead opens a two-byte sequence only.
	a_lead_kind: assert property (@(posedge clk) disable iff (!arst_n)
		lead_kind_q != LK_OTHER |-> bytes_left_q == 2'd1 && !four_q)
		else $error("Latin-1 lead kind with a longer sequence");
`endif

endmodule
